// File: src/chr_pkg.sv
`timescale 1ns / 1ps
package chr_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IW         = $clog2(RING_DEPTH);
  localparam int CW         = $clog2(RING_DEPTH + 1);
  localparam int KEY_W      = 32;
  localparam int EP_W       = 48;
  localparam int RETRY_W    = 8;
  localparam int STEP_W     = $clog2(RETRY_W);
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;

  localparam logic [CMD_W-1:0] CMD_SELECT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_DEAD   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_ALIVE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR_DEAD = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_MARK,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IW-1:0]     pos;
    logic [KEY_W-1:0]  key;
    logic [EP_W-1:0]   ep;
    logic              dead;
  } cell_ctl_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [EP_W-1:0]   ep;
    logic              dead;
  } cell_data_t;

endpackage

// File: src/chr_if.sv
`timescale 1ns / 1ps
interface chr_req_if;
  logic                          valid;
  logic                          ready;
  logic [chr_pkg::CMD_W-1:0]     command;
  logic [chr_pkg::KEY_W-1:0]     hash_key;
  logic [chr_pkg::EP_W-1:0]      endpoint_id;
  logic [chr_pkg::RETRY_W-1:0]   prior_tries;
  modport source (output valid, command, hash_key, endpoint_id, prior_tries, input ready);
  modport sink (input valid, command, hash_key, endpoint_id, prior_tries, output ready);
endinterface

interface chr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [chr_pkg::STATUS_W-1:0]  status;
  logic [chr_pkg::EP_W-1:0]      chosen_endpoint;
  logic [chr_pkg::CW-1:0]        entry_count;
  modport source (output valid, status, chosen_endpoint, entry_count, input ready);
  modport sink (input valid, status, chosen_endpoint, entry_count, output ready);
endinterface

// File: src/chr_cell.sv
`timescale 1ns / 1ps
module chr_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [chr_pkg::IW-1:0] idx,
  input  chr_pkg::cell_ctl_t    ctl,
  input  chr_pkg::cell_data_t   prev,
  input  chr_pkg::cell_data_t   next,
  output chr_pkg::cell_data_t   data,
  output logic                  key_le,
  output logic                  key_eq,
  output logic                  ep_eq
);
  import chr_pkg::*;

  logic [KEY_W-1:0] ring_key;
  logic [EP_W-1:0]  ring_ep;
  logic             dead;

  assign data   = {ring_key, ring_ep, dead};
  assign key_le = ring_key <= ctl.key;
  assign key_eq = ring_key == ctl.key;
  assign ep_eq  = ring_ep == ctl.ep;

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INSERT: begin
        if (idx > ctl.pos) begin
          ring_key <= prev.key;
          ring_ep  <= prev.ep;
        end else if (idx == ctl.pos) begin
          ring_key <= ctl.key;
          ring_ep  <= ctl.ep;
        end
      end
      CELL_DELETE: begin
        if (idx >= ctl.pos) begin
          ring_key <= next.key;
          ring_ep  <= next.ep;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dead <= 1'b0;
    end else begin
      case (ctl.op)
        CELL_INSERT: begin
          if (idx > ctl.pos) dead <= prev.dead;
          else if (idx == ctl.pos) dead <= 1'b0;
        end
        CELL_DELETE: if (idx >= ctl.pos) dead <= next.dead;
        CELL_MARK:   if (idx == ctl.pos) dead <= ctl.dead;
        CELL_CLEAR:  dead <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

// File: src/chr_rmod.sv
`timescale 1ns / 1ps
module chr_rmod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [chr_pkg::RETRY_W-1:0] dividend,
  input  logic [chr_pkg::CW-1:0]      divisor,
  output logic                       done,
  output logic [chr_pkg::CW-1:0]      rem
);
  import chr_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [RETRY_W-1:0] shreg;
  logic [CW:0]       trial;

  assign trial = {rem, shreg[RETRY_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        step  <= '0;
        shreg <= dividend;
        rem   <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) rem <= CW'(trial - {1'b0, divisor});
        else rem <= trial[CW-1:0];
        shreg <= {shreg[RETRY_W-2:0], 1'b0};
        step  <= step + 1'b1;
        if (step == STEP_W'(RETRY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/consistent_hash_ring_selector_unit.sv
`timescale 1ns / 1ps
// channel | dir | words
// req     | in  | command, hash_key, endpoint_id, prior_tries
// rsp     | out | status, chosen_endpoint, entry_count
//
// Table commands run EVAL, APPLY; select runs EVAL, DIV (bit-serial retry
// modulo unit), WRAP, PICK, FETCH, or EVAL alone on an empty ring, then DONE.
// One item is in flight; req is taken again once its result is registered.
// rsp stalls hold the finished word; the next item may be accepted meanwhile.
// Synchronous reset clears the dead marks, counts and handshake state.
module consistent_hash_ring_selector_unit (
  input logic     clk,
  input logic     rst,
  chr_req_if.sink req,
  chr_rsp_if.source rsp
);
  import chr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EVAL  = 8'b0000_0010,
    S_APPLY = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_WRAP  = 8'b0001_0000,
    S_PICK  = 8'b0010_0000,
    S_FETCH = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t              state;
  logic [CMD_W-1:0]    cur_cmd;
  logic [KEY_W-1:0]    cur_key;
  logic [EP_W-1:0]     cur_ep;
  logic [RETRY_W-1:0]  cur_retry;
  logic [CW-1:0]       count;
  logic [CW-1:0]       dcnt;
  logic [CW-1:0]       pos_r;
  logic                present_r;
  logic                matched_r;
  logic [IW-1:0]       midx_r;
  logic                mdead_r;
  logic [IW-1:0]       sel_pos;
  logic [IW-1:0]       fin_idx;
  status_t             res_status;
  logic [EP_W-1:0]     res_ep;

  cell_ctl_t           ctl;
  cell_data_t          cd [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_v, le_v, eq_v, epq_v, dead_v, alive_v;

  logic [CW-1:0]       pos0;
  logic                present;
  logic [RING_DEPTH-1:0] match_v;
  logic [IW-1:0]       midx;
  logic [CW:0]         wsum;
  logic [IW-1:0]       first_hi, first_any;
  logic                hi_found;

  logic                div_start, div_done;
  logic [CW-1:0]       div_rem;

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    cell_data_t p, n;
    if (i == 0) begin : g_first
      assign p = '0;
    end else begin : g_prev
      assign p = cd[i-1];
    end
    if (i == RING_DEPTH - 1) begin : g_last
      assign n = '0;
    end else begin : g_next
      assign n = cd[i+1];
    end
    chr_cell u_cell (
      .clk(clk), .rst(rst), .idx(IW'(i)), .ctl(ctl), .prev(p), .next(n),
      .data(cd[i]), .key_le(le_v[i]), .key_eq(eq_v[i]), .ep_eq(epq_v[i])
    );
    assign valid_v[i] = CW'(i) < count;
    assign dead_v[i]  = cd[i].dead;
    assign alive_v[i] = valid_v[i] & ~cd[i].dead;
  end

  chr_rmod u_rmod (
    .clk(clk), .rst(rst), .start(div_start), .dividend(cur_retry),
    .divisor(count), .done(div_done), .rem(div_rem)
  );

  assign div_start = (state == S_EVAL) && (cur_cmd == CMD_SELECT) && (count != '0);
  assign match_v   = valid_v & eq_v & epq_v;
  assign present   = |(valid_v & eq_v);
  assign wsum      = {1'b0, pos_r} + {1'b0, div_rem};

  always_comb begin
    pos0 = count;
    midx = '0;
    for (int i = RING_DEPTH - 1; i >= 0; i--) begin
      if (valid_v[i] && !le_v[i]) pos0 = CW'(i);
    end
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (match_v[i]) midx = midx | IW'(i);
    end
  end

  always_comb begin
    first_hi  = '0;
    first_any = '0;
    hi_found  = 1'b0;
    for (int i = RING_DEPTH - 1; i >= 0; i--) begin
      if (alive_v[i]) first_any = IW'(i);
      if (alive_v[i] && IW'(i) > sel_pos) begin
        first_hi = IW'(i);
        hi_found = 1'b1;
      end
    end
  end

  always_comb begin
    ctl.op   = CELL_HOLD;
    ctl.pos  = midx_r;
    ctl.key  = cur_key;
    ctl.ep   = cur_ep;
    ctl.dead = (cur_cmd == CMD_SET_DEAD);
    if (state == S_APPLY) begin
      case (cur_cmd)
        CMD_ADD: begin
          if (!present_r && count != CW'(RING_DEPTH)) begin
            ctl.op  = CELL_INSERT;
            ctl.pos = pos_r[IW-1:0];
          end
        end
        CMD_REMOVE: if (matched_r) ctl.op = CELL_DELETE;
        CMD_SET_DEAD, CMD_SET_ALIVE: if (matched_r) ctl.op = CELL_MARK;
        CMD_CLEAR_DEAD: ctl.op = CELL_CLEAR;
        default: ;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dcnt      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur_cmd   <= req.command;
            cur_key   <= req.hash_key;
            cur_ep    <= req.endpoint_id;
            cur_retry <= req.prior_tries;
            state     <= S_EVAL;
          end
        end
        S_EVAL: begin
          present_r  <= present;
          matched_r  <= |match_v;
          midx_r     <= midx;
          mdead_r    <= |(match_v & dead_v);
          res_status <= ST_OK;
          res_ep     <= '0;
          pos_r      <= (cur_cmd == CMD_SELECT && pos0 >= count) ? '0 : pos0;
          if (cur_cmd != CMD_SELECT) begin
            state <= S_APPLY;
          end else if (count == '0) begin
            res_status <= ST_NONE;
            state      <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_APPLY: begin
          state <= S_DONE;
          case (cur_cmd)
            CMD_ADD: begin
              if (present_r) res_status <= ST_NOMATCH;
              else if (count == CW'(RING_DEPTH)) res_status <= ST_FULL;
              else count <= count + 1'b1;
            end
            CMD_REMOVE: begin
              if (!matched_r) begin
                res_status <= ST_NOMATCH;
              end else begin
                count <= count - 1'b1;
                if (mdead_r) dcnt <= dcnt - 1'b1;
              end
            end
            CMD_SET_DEAD: begin
              if (!matched_r) res_status <= ST_NOMATCH;
              else if (!mdead_r) dcnt <= dcnt + 1'b1;
            end
            CMD_SET_ALIVE: begin
              if (!matched_r) res_status <= ST_NOMATCH;
              else if (mdead_r) dcnt <= dcnt - 1'b1;
            end
            CMD_CLEAR_DEAD: dcnt <= '0;
            default: ;
          endcase
        end
        S_DIV: if (div_done) state <= S_WRAP;
        S_WRAP: begin
          if (wsum >= {1'b0, count}) sel_pos <= IW'(wsum - {1'b0, count});
          else sel_pos <= wsum[IW-1:0];
          state <= S_PICK;
        end
        S_PICK: begin
          if (cur_retry == '0 || dcnt >= count || !dead_v[sel_pos]) fin_idx <= sel_pos;
          else if (hi_found) fin_idx <= first_hi;
          else fin_idx <= first_any;
          state <= S_FETCH;
        end
        S_FETCH: begin
          res_ep <= cd[fin_idx].ep;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid           <= 1'b1;
            rsp.status          <= res_status;
            rsp.chosen_endpoint <= res_ep;
            rsp.entry_count     <= count;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/chr_checker.sv
`timescale 1ns / 1ps
module chr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [chr_pkg::STATUS_W-1:0] rsp_status,
  input logic [chr_pkg::EP_W-1:0]     rsp_chosen,
  input logic [chr_pkg::CW-1:0]       rsp_count
);
  import chr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_chosen))
    else $error("rsp word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_count <= CW'(RING_DEPTH))
    else $error("entry count beyond ring depth");

  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_count == CW'(RING_DEPTH))
    else $error("full status with room left");

  a_chosen_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_chosen == '0)
    else $error("endpoint on failed word");

endmodule

bind consistent_hash_ring_selector_unit chr_checker u_chk (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_chosen(rsp.chosen_endpoint),
  .rsp_count(rsp.entry_count)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import chr_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    status_t            status;
    logic [EP_W-1:0]    chosen;
    logic [CW-1:0]      count;
  } ring_result_t;

  logic clk;
  logic rst;
  chr_req_if req_if ();
  chr_rsp_if rsp_if ();

  consistent_hash_ring_selector_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  logic [KEY_W-1:0] ring_key [RING_DEPTH];
  logic [EP_W-1:0]  ring_ep [RING_DEPTH];
  logic             ring_dead [RING_DEPTH];
  int               ring_size;
  int               dead_total;
  ring_result_t     pending_results [$];
  int               mismatches;
  int               results_seen;
  int               selects_sent;
  int               idle_cycles;
  bit               idle_on;

  always #10 clk = ~clk;

  function automatic int first_key_above(logic [KEY_W-1:0] k);
    int i;
    i = 0;
    while (i < ring_size && ring_key[i] <= k) i++;
    return i;
  endfunction

  function automatic int entry_of(logic [KEY_W-1:0] k, logic [EP_W-1:0] ep);
    for (int i = 0; i < ring_size; i++)
      if (ring_key[i] == k) return (ring_ep[i] == ep) ? i : -1;
    return -1;
  endfunction

  function automatic ring_result_t ring_apply(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                                              logic [EP_W-1:0] ep, logic [RETRY_W-1:0] retry);
    ring_result_t r;
    int pos;
    bit found;
    r.status = ST_OK;
    r.chosen = '0;
    case (cmd)
      CMD_SELECT: begin
        if (ring_size == 0) begin
          r.status = ST_NONE;
        end else begin
          pos = first_key_above(k);
          if (pos >= ring_size) pos = 0;
          pos = (pos + int'(retry) % ring_size) % ring_size;
          if (retry == 0 || dead_total >= ring_size || !ring_dead[pos]) begin
            r.chosen = ring_ep[pos];
          end else begin
            found = 0;
            for (int i = 0; i < ring_size && !found; i++) begin
              pos = (pos + 1) % ring_size;
              if (!ring_dead[pos]) begin
                r.chosen = ring_ep[pos];
                found = 1;
              end
            end
            if (!found) r.status = ST_NONE;
          end
        end
      end
      CMD_ADD: begin
        found = 0;
        for (int i = 0; i < ring_size; i++) if (ring_key[i] == k) found = 1;
        if (found) begin
          r.status = ST_NOMATCH;
        end else if (ring_size >= RING_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = first_key_above(k);
          for (int i = ring_size; i > pos; i--) begin
            ring_key[i] = ring_key[i-1];
            ring_ep[i] = ring_ep[i-1];
            ring_dead[i] = ring_dead[i-1];
          end
          ring_key[pos] = k;
          ring_ep[pos] = ep;
          ring_dead[pos] = 0;
          ring_size++;
        end
      end
      CMD_REMOVE: begin
        pos = entry_of(k, ep);
        if (pos < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          if (ring_dead[pos] && dead_total > 0) dead_total--;
          for (int i = pos; i + 1 < ring_size; i++) begin
            ring_key[i] = ring_key[i+1];
            ring_ep[i] = ring_ep[i+1];
            ring_dead[i] = ring_dead[i+1];
          end
          ring_size--;
          ring_dead[ring_size] = 0;
        end
      end
      CMD_SET_DEAD, CMD_SET_ALIVE: begin
        pos = entry_of(k, ep);
        if (pos < 0) begin
          r.status = ST_NOMATCH;
        end else if (ring_dead[pos] != (cmd == CMD_SET_DEAD)) begin
          ring_dead[pos] = (cmd == CMD_SET_DEAD);
          if (cmd == CMD_SET_DEAD) dead_total++;
          else if (dead_total > 0) dead_total--;
        end
      end
      CMD_CLEAR_DEAD: begin
        for (int i = 0; i < RING_DEPTH; i++) ring_dead[i] = 0;
        dead_total = 0;
      end
      default: ;
    endcase
    r.count = CW'(ring_size);
    return r;
  endfunction

  task automatic send_word(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                           logic [EP_W-1:0] ep, logic [RETRY_W-1:0] retry);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < 36) gap++;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.command     <= cmd;
    req_if.hash_key    <= k;
    req_if.endpoint_id <= ep;
    req_if.prior_tries <= retry;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(ring_apply(cmd, k, ep, retry));
    if (cmd == CMD_SELECT) selects_sent++;
  endtask

  function automatic logic [EP_W-1:0] rand_ep();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic pick_entry(output logic [KEY_W-1:0] k, output logic [EP_W-1:0] ep);
    int i;
    if (ring_size == 0) begin
      k = $urandom;
      ep = rand_ep();
    end else begin
      i = $urandom_range(ring_size - 1);
      k = ring_key[i];
      ep = ring_ep[i];
    end
  endtask

  task automatic test_directed();
    logic [KEY_W-1:0] k;
    logic [EP_W-1:0]  ep;
    send_word(CMD_SELECT, 32'h1234_5678, '0, 8'd0);
    send_word(CMD_ADD, 32'h0000_0000, 48'h0, 8'd0);
    send_word(CMD_ADD, 32'hFFFF_FFFF, {EP_W{1'b1}}, 8'hFF);
    send_word(CMD_ADD, 32'h8000_0000, 48'h5555_AAAA_5555, 8'd0);
    send_word(CMD_ADD, 32'h8000_0000, 48'h1, 8'd0);
    send_word(CMD_SELECT, 32'hFFFF_FFFF, '0, 8'd0);
    send_word(CMD_SELECT, 32'h0000_0000, {EP_W{1'b1}}, 8'hFF);
    send_word(CMD_REMOVE, 32'h8000_0000, 48'h1, 8'd0);
    send_word(CMD_SET_DEAD, 32'h8000_0000, 48'h7, 8'd0);
    send_word(CMD_SET_DEAD, 32'h8000_0000, 48'h5555_AAAA_5555, 8'd0);
    send_word(CMD_SET_DEAD, 32'h8000_0000, 48'h5555_AAAA_5555, 8'd0);
    send_word(CMD_SELECT, 32'h7FFF_FFFF, '0, 8'd0);
    send_word(CMD_SELECT, 32'h7FFF_FFFF, '0, 8'd3);
    send_word(CMD_SET_ALIVE, 32'h8000_0000, 48'h5555_AAAA_5555, 8'd0);
    send_word(CMD_SET_ALIVE, 32'h8000_0000, 48'h5555_AAAA_5555, 8'd0);
    send_word(CMD_SET_DEAD, 32'h0000_0000, 48'h0, 8'd0);
    send_word(CMD_SET_DEAD, 32'hFFFF_FFFF, {EP_W{1'b1}}, 8'd0);
    send_word(CMD_SET_DEAD, 32'h8000_0000, 48'h5555_AAAA_5555, 8'd0);
    send_word(CMD_SELECT, 32'h0, '0, 8'd2);
    send_word(CMD_REMOVE, 32'h0000_0000, 48'h0, 8'd0);
    send_word(CMD_CLEAR_DEAD, '0, '0, 8'd0);
    send_word(CMD_SPARE_LO, 32'hDEAD_BEEF, rand_ep(), 8'd9);
    send_word(CMD_SPARE_HI, 32'hFFFF_FFFF, {EP_W{1'b1}}, 8'hFF);
    send_word(CMD_SELECT, 32'h8000_0000, '0, 8'hFF);
    while (ring_size > 0) begin
      pick_entry(k, ep);
      send_word(CMD_REMOVE, k, ep, 8'd0);
    end
  endtask

  task automatic test_full_ring();
    logic [KEY_W-1:0] k;
    logic [EP_W-1:0]  ep;
    while (ring_size < RING_DEPTH) send_word(CMD_ADD, $urandom, rand_ep(), 8'd0);
    send_word(CMD_ADD, $urandom, rand_ep(), 8'd0);
    pick_entry(k, ep);
    send_word(CMD_ADD, k, rand_ep(), 8'd0);
    for (int i = 0; i < RING_DEPTH; i++)
      if (i != 5) send_word(CMD_SET_DEAD, ring_key[i], ring_ep[i], 8'd0);
    repeat (6) send_word(CMD_SELECT, $urandom, '0, 8'($urandom));
    send_word(CMD_SET_DEAD, ring_key[5], ring_ep[5], 8'd0);
    repeat (4) send_word(CMD_SELECT, $urandom, '0, 8'($urandom));
    send_word(CMD_CLEAR_DEAD, '0, '0, 8'd0);
    while (ring_size > 2) begin
      pick_entry(k, ep);
      send_word(CMD_REMOVE, k, ep, 8'd0);
    end
  endtask

  task automatic test_random_traffic(int n_items);
    logic [KEY_W-1:0] k;
    logic [EP_W-1:0]  ep;
    logic [CMD_W-1:0] cmd;
    int roll;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      pick_entry(k, ep);
      if (roll < 35) begin
        cmd = CMD_SELECT;
        k = ($urandom_range(3) == 0) ? k + 32'($urandom_range(2)) - 1 : $urandom;
      end else if (roll < 55) begin
        cmd = CMD_ADD;
        if (ring_size > 48 || $urandom_range(9) == 0) ep = rand_ep();
        else begin
          k = $urandom;
          ep = rand_ep();
        end
      end else if (roll < 67) begin
        cmd = CMD_REMOVE;
      end else if (roll < 82) begin
        cmd = CMD_SET_DEAD;
      end else if (roll < 92) begin
        cmd = CMD_SET_ALIVE;
      end else if (roll < 96) begin
        cmd = CMD_CLEAR_DEAD;
      end else begin
        cmd = 3'($urandom_range(7));
        k = $urandom;
      end
      if (cmd != CMD_SELECT && cmd != CMD_ADD && $urandom_range(9) == 0)
        ep = ep ^ (48'h1 << $urandom_range(EP_W - 1));
      send_word(cmd, k, ep, ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom));
    end
  endtask

  task automatic test_no_idle_burst();
    idle_on = 0;
    test_random_traffic(120);
    idle_on = 1;
  endtask

  always @(posedge clk) begin
    if (rst) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= !idle_on || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    ring_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: status %0d", rsp_if.status);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status || rsp_if.chosen_endpoint !== want.chosen
            || rsp_if.entry_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d ep %h cnt %0d, got st %0d ep %h cnt %0d",
                     want.status, want.chosen, want.count, rsp_if.status,
                     rsp_if.chosen_endpoint, rsp_if.entry_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clk = 0;
    rst <= 1'b1;
    idle_on = 1;
    ring_size = 0;
    dead_total = 0;
    mismatches = 0;
    results_seen = 0;
    selects_sent = 0;
    idle_cycles = 0;
    for (int i = 0; i < RING_DEPTH; i++) ring_dead[i] = 0;
    req_if.valid <= 1'b0;
    req_if.command <= CMD_SELECT;
    req_if.hash_key <= '0;
    req_if.endpoint_id <= '0;
    req_if.prior_tries <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_ring();
    test_random_traffic(240);
    test_no_idle_burst();
    test_random_traffic(240);
    req_if.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("ran %0d result words (%0d selects) through add, remove, mark, clear and select",
             results_seen, selects_sent);
    $display("ring filled to its depth once, random traffic with and without stalls");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
src/chr_pkg.sv
src/chr_if.sv
src/chr_cell.sv
src/chr_rmod.sv
src/consistent_hash_ring_selector_unit.sv
src/chr_checker.sv
dv/tb_top.sv
